FILE: rtl/gtsm_pkg.sv
// Shared constants, codes and types of the greedy token subsequence match core.
// No dependencies.
`timescale 1ns / 1ps

package gtsm_pkg;

  localparam int unsigned MAX_TOKENS      = 64;
  localparam int unsigned MAX_TOKEN_CHARS = 8;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned WORD_W  = MAX_TOKEN_CHARS * CHAR_W;
  localparam int unsigned SLOT_W  = $clog2(MAX_TOKENS);
  localparam int unsigned CNT_W   = $clog2(MAX_TOKENS + 1);
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned SEEN_W  = $clog2(MAX_TOKEN_CHARS + 1);

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOKEN_LENGTH = 2'd0,
    CFG_TOKEN_COUNT  = 2'd1
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_CHAR = 1'b1
  } op_e;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [CNT_W-1:0] cnt;
  } cfg_t;

  typedef struct packed {
    logic adv;
    logic restart;
  } store_step_t;

endpackage

FILE: rtl/gtsm_cfg_regs.sv
// Configuration registers of the match core, with clamped working values.
// Depends on gtsm_pkg.
`timescale 1ns / 1ps

module gtsm_cfg_regs
  import gtsm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  logic [LEN_W-1:0] len_q, len_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    len_d = len_q;
    cnt_d = cnt_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TOKEN_LENGTH: len_d = cfg_data_i[LEN_W-1:0];
        CFG_TOKEN_COUNT:  cnt_d = cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_W'(1);
      cnt_q <= '0;
    end else begin
      len_q <= len_d;
      cnt_q <= cnt_d;
    end
  end

  always_comb begin
    priority if (len_q == '0) begin
      cfg_o.len = LEN_W'(1);
    end else if (len_q > LEN_W'(MAX_TOKEN_CHARS)) begin
      cfg_o.len = LEN_W'(MAX_TOKEN_CHARS);
    end else begin
      cfg_o.len = len_q;
    end
    cfg_o.cnt = (cnt_q > CNT_W'(MAX_TOKENS)) ? CNT_W'(MAX_TOKENS) : cnt_q;
  end

endmodule

FILE: rtl/gtsm_token_store.sv
// Token store: one write port, two registered read ports at the sought slot and
// the one after it, and a copy of slot zero for a fresh sequence. Depends on gtsm_pkg.
`timescale 1ns / 1ps

module gtsm_token_store
  import gtsm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [SLOT_W-1:0] wr_addr_i,
  input  logic [WORD_W-1:0] wr_data_i,
  input  logic [SLOT_W-1:0] rd_addr_i,
  input  store_step_t       step_i,
  output logic [WORD_W-1:0] token_o
);

  logic [WORD_W-1:0] mem [MAX_TOKENS];
  logic [WORD_W-1:0] rd_a_q, rd_b_q, tok0_q;
  logic [SLOT_W-1:0] rd_addr_b;
  store_step_t       step_q;

  assign rd_addr_b = rd_addr_i + SLOT_W'(1);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_a_q <= (wr_en_i && wr_addr_i == rd_addr_i) ? wr_data_i : mem[rd_addr_i];
    rd_b_q <= (wr_en_i && wr_addr_i == rd_addr_b) ? wr_data_i : mem[rd_addr_b];
    if (wr_en_i && wr_addr_i == '0) begin
      tok0_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_i;
    end
  end

  always_comb begin
    priority if (step_q.restart) begin
      token_o = tok0_q;
    end else if (step_q.adv) begin
      token_o = rd_b_q;
    end else begin
      token_o = rd_a_q;
    end
  end

endmodule

FILE: rtl/greedy_token_subsequence_match_core.sv
// Top level of the greedy token subsequence match core: input register, window
// compare, sequence state and result register. Depends on gtsm_pkg, gtsm_cfg_regs
// and gtsm_token_store.
//
//   channel  direction  handshake                        payload
//   s_axis   in         s_axis_tvalid / s_axis_tready    tdata, tuser (op), tlast
//   m_axis   out        m_axis_tvalid / m_axis_tready    tdata (match_count)
//   cfg      in         cfg_valid_i / cfg_ready_o        cfg_index_i, cfg_data_i
//
// One item a cycle unless a stalled result holds the input register.
// The rate is set by the combinational window compare against the sought token, which
// the store keeps ready from its two registered read ports.
// Reset clears the window, the counters and the handshake state; the store is not cleared.
// A stalled result holds the input register only when the waiting item also ends a run.
`timescale 1ns / 1ps

module greedy_token_subsequence_match_core
  import gtsm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [5:0] token_slot, [69:6] token_word, [77:70] seq_char, [79:78] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] op
  input  logic                  s_axis_tuser,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [6:0] match_count, [7] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg;

  logic              in_valid_q;
  op_e               in_op_q;
  logic [SLOT_W-1:0] in_slot_q;
  logic [WORD_W-1:0] in_word_q;
  logic [CHAR_W-1:0] in_char_q;
  logic              in_last_q;

  logic [WORD_W-1:0] win_q, win_d;
  logic [SEEN_W-1:0] seen_q, seen_d;
  logic [CNT_W-1:0]  nt_q, nt_d, nt_inc;

  logic              out_valid_q, out_valid_d;
  logic [CNT_W-1:0]  out_count_q, out_count_d;

  logic              fire, is_char, has_result, out_free, hit, accept;
  logic [WORD_W-1:0] token, view, mask;
  logic [LEN_W-1:0]  gap;
  store_step_t       step;

  gtsm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  gtsm_token_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (fire && in_op_q == OP_LOAD),
    .wr_addr_i (in_slot_q),
    .wr_data_i (in_word_q),
    .rd_addr_i (nt_q[SLOT_W-1:0]),
    .step_i    (step),
    .token_o   (token)
  );

  assign is_char       = in_op_q == OP_CHAR;
  assign has_result    = is_char && in_last_q;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && (!has_result || out_free);
  assign s_axis_tready = !in_valid_q || fire;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    win_d  = {in_char_q, win_q[WORD_W-1:CHAR_W]};
    seen_d = (seen_q < SEEN_W'(MAX_TOKEN_CHARS)) ? seen_q + SEEN_W'(1) : seen_q;
    gap    = LEN_W'(MAX_TOKEN_CHARS) - cfg.len;
    view   = win_d >> {gap, 3'b000};
    for (int i = 0; i < MAX_TOKEN_CHARS; i++) begin
      mask[i*CHAR_W +: CHAR_W] = {CHAR_W{LEN_W'(i) < cfg.len}};
    end
    hit    = (LEN_W'(seen_d) >= cfg.len) && (nt_q < cfg.cnt) && (view == (token & mask));
    nt_inc = nt_q + CNT_W'(hit);
    nt_d   = in_last_q ? '0 : nt_inc;
  end

  assign step.adv     = fire && is_char && hit && !in_last_q;
  assign step.restart = fire && has_result;

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    out_count_d = out_count_q;
    if (fire && has_result) begin
      out_valid_d = 1'b1;
      out_count_d = nt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      win_q       <= '0;
      seen_q      <= '0;
      nt_q        <= '0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      out_valid_q <= out_valid_d;
      if (fire && is_char) begin
        win_q  <= in_last_q ? '0 : win_d;
        seen_q <= in_last_q ? '0 : seen_d;
        nt_q   <= nt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_op_q   <= op_e'(s_axis_tuser);
      in_slot_q <= s_axis_tdata[SLOT_W-1:0];
      in_word_q <= s_axis_tdata[SLOT_W +: WORD_W];
      in_char_q <= s_axis_tdata[SLOT_W+WORD_W +: CHAR_W];
      in_last_q <= s_axis_tlast;
    end
    out_count_q <= out_count_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_count_q);

endmodule

FILE: tb/sv/greedy_token_subsequence_match_core_tb.sv
// Self-checking bench for the greedy token subsequence match core: a scoreboard class
// predicts each match count and plain tasks drive the item and register channels.
// Depends on gtsm_pkg and greedy_token_subsequence_match_core.
`timescale 1ns / 1ps

import gtsm_pkg::*;

class match_scoreboard;
  logic [WORD_W-1:0] tokens [MAX_TOKENS];
  logic [WORD_W-1:0] window;
  int unsigned       seen;
  int unsigned       next_tok;
  logic [LEN_W-1:0]  tok_len;
  logic [CNT_W-1:0]  tok_cnt;
  logic [CNT_W-1:0]  counts_q [$];
  int unsigned       errors;
  int unsigned       n_results;

  function new();
    foreach (tokens[i]) tokens[i] = '0;
    window    = '0;
    seen      = 0;
    next_tok  = 0;
    tok_len   = 4'd1;
    tok_cnt   = '0;
    errors    = 0;
    n_results = 0;
  endfunction

  function int unsigned eff_len();
    if (tok_len == 0) return 1;
    if (tok_len > MAX_TOKEN_CHARS) return MAX_TOKEN_CHARS;
    return tok_len;
  endfunction

  function int unsigned eff_cnt();
    if (tok_cnt > MAX_TOKENS) return MAX_TOKENS;
    return tok_cnt;
  endfunction

  function int unsigned pending();
    return counts_q.size();
  endfunction

  function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_TOKEN_LENGTH) tok_len = data[LEN_W-1:0];
    else if (idx == CFG_TOKEN_COUNT) tok_cnt = data[CNT_W-1:0];
  endfunction

  function void note_input(op_e op, logic [SLOT_W-1:0] slot, logic [WORD_W-1:0] word,
                           logic [CHAR_W-1:0] ch, logic last);
    int unsigned       len;
    logic [WORD_W-1:0] keep;
    logic [WORD_W-1:0] view;
    if (op == OP_LOAD) begin
      tokens[slot] = word;
      return;
    end
    len    = eff_len();
    window = {ch, window[WORD_W-1:CHAR_W]};
    if (seen < MAX_TOKEN_CHARS) seen++;
    if (seen >= len && next_tok < eff_cnt()) begin
      keep = {WORD_W{1'b1}} >> (WORD_W - len * CHAR_W);
      view = window >> (WORD_W - len * CHAR_W);
      if ((tokens[next_tok] & keep) == view) next_tok++;
    end
    if (last) begin
      counts_q.push_back(next_tok[CNT_W-1:0]);
      window   = '0;
      seen     = 0;
      next_tok = 0;
    end
  endfunction

  function void check_result(logic [OUT_DATA_W-1:0] data);
    logic [CNT_W-1:0] want;
    n_results++;
    if (counts_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected match_count, expected none, actual %0d", $time,
               data[CNT_W-1:0]);
      return;
    end
    want = counts_q.pop_front();
    if (data[CNT_W-1:0] !== want) begin
      errors++;
      $display("%0t: match_count mismatch, expected %0d, actual %0d", $time, want,
               data[CNT_W-1:0]);
    end
  endfunction
endclass

module greedy_token_subsequence_match_core_tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  match_scoreboard   sb = new();
  logic [WORD_W-1:0] pattern [MAX_TOKENS];
  bit                steady = 1'b0;
  int unsigned       cycles = 0;
  int unsigned       n_items = 0;
  int unsigned       n_settings = 0;
  int unsigned       cur_len = 1;
  int unsigned       cur_cnt = 0;
  int unsigned       alpha = 2;

  greedy_token_subsequence_match_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    m_axis_tready <= steady || ($urandom_range(99) >= 13);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [WORD_W-1:0] make_token();
    logic [WORD_W-1:0] w;
    w = {$urandom, $urandom};
    for (int i = 0; i < cur_len; i++)
      w[i*CHAR_W +: CHAR_W] = CHAR_W'(8'h61 + $urandom_range(alpha - 1));
    return w;
  endfunction

  task automatic drive_item(op_e op, logic [SLOT_W-1:0] slot, logic [WORD_W-1:0] word,
                            logic [CHAR_W-1:0] ch, logic last);
    while (!steady && $urandom_range(99) < 13) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, ch, word, slot};
    s_axis_tuser  <= op;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    sb.note_input(op, slot, word, ch, last);
    n_items++;
  endtask

  task automatic send_load(logic [SLOT_W-1:0] slot, logic [WORD_W-1:0] word);
    pattern[slot] = word;
    drive_item(OP_LOAD, slot, word, CHAR_W'($urandom), 1'($urandom));
  endtask

  task automatic send_char(logic [CHAR_W-1:0] ch, logic last);
    drive_item(OP_CHAR, SLOT_W'($urandom), {$urandom, $urandom}, ch, last);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    sb.note_config(idx, data);
    n_settings++;
    cur_len = sb.eff_len();
    cur_cnt = sb.eff_cnt();
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // hold the sender until every count is back, then let the pipeline settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  initial begin
    int unsigned       phase;
    int unsigned       nseq;
    int unsigned       n_emit;
    logic [CFG_DATA_W-1:0] len_data;
    logic [CFG_DATA_W-1:0] cnt_data;
    logic [CHAR_W-1:0] text_q [$];

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < MAX_TOKENS; i++) send_load(SLOT_W'(i), {$urandom, $urandom});

    send_text("xy");
    drain();
    write_reg(CFG_TOKEN_LENGTH, 8'h03);
    write_reg(CFG_TOKEN_COUNT, 8'h03);
    send_load(0, 64'hA5A5_A5A5_A563_6261);
    send_load(1, 64'h0123_4567_8964_6362);
    send_load(2, 64'hFFFF_FFFF_FF65_6463);
    send_text("abcde");
    send_text("ab");
    send_text("zzabczcdexx");
    drain();
    write_reg(CFG_TOKEN_LENGTH, 8'hF0);
    write_reg(CFG_TOKEN_COUNT, 8'h82);
    send_text("xab");
    drain();
    write_reg(CFG_TOKEN_LENGTH, 8'h0F);
    write_reg(CFG_TOKEN_COUNT, 8'h7F);
    write_reg(CFG_SPARE_LO, 8'hFF);
    write_reg(CFG_SPARE_HI, 8'h00);
    send_load(0, 64'h6867_6665_6463_6261);
    send_text("xabcdefgh");

    phase = 0;
    while (n_items < 630) begin
      drain();
      steady = (phase == 0);
      if (phase == 0) begin
        len_data = {4'($urandom), 4'd1};
        cnt_data = 8'h7F;
      end else begin
        case ($urandom_range(9))
          0:       cnt_data = 8'd0;
          1:       cnt_data = 8'd64;
          2:       cnt_data = 8'($urandom_range(65, 127));
          default: cnt_data = 8'($urandom_range(1, 8));
        endcase
        cnt_data[7] = 1'($urandom);
        if (cnt_data[6:0] > 8) len_data[3:0] = 4'($urandom_range(2));
        else begin
          case ($urandom_range(5))
            0:       len_data[3:0] = 4'd0;
            1:       len_data[3:0] = 4'd15;
            2:       len_data[3:0] = 4'($urandom_range(9, 14));
            default: len_data[3:0] = 4'($urandom_range(1, 8));
          endcase
        end
        len_data[7:4] = 4'($urandom);
      end
      if ($urandom_range(1)) begin
        write_reg(CFG_TOKEN_LENGTH, len_data);
        write_reg(CFG_TOKEN_COUNT, cnt_data);
      end else begin
        write_reg(CFG_TOKEN_COUNT, cnt_data);
        write_reg(CFG_TOKEN_LENGTH, len_data);
      end
      if ($urandom_range(4) == 0) write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                                            CFG_DATA_W'($urandom));
      alpha = $urandom_range(2, 4);
      for (int i = 0; i < cur_cnt; i++)
        if ($urandom_range(3) != 0) send_load(SLOT_W'(i), make_token());

      nseq = (phase == 0) ? 2 : $urandom_range(3, 8);
      for (int s = 0; s < nseq; s++) begin
        text_q.delete();
        if ($urandom_range(4) == 0) begin
          repeat ($urandom_range(1, 12)) text_q.push_back(CHAR_W'($urandom));
        end else begin
          n_emit = cur_cnt;
          if (phase != 0 && cur_cnt > 8 && $urandom_range(3) != 0) n_emit = $urandom_range(1, 8);
          for (int k = 0; k < n_emit; k++) begin
            repeat ($urandom_range(2))
              text_q.push_back(CHAR_W'(8'h61 + $urandom_range(alpha - 1)));
            for (int j = 0; j < cur_len; j++) text_q.push_back(pattern[k][j*CHAR_W +: CHAR_W]);
            if ($urandom_range(9) == 0)
              text_q[text_q.size() - 1 - $urandom_range(cur_len - 1)] = CHAR_W'($urandom);
          end
          repeat ($urandom_range(2))
            text_q.push_back(CHAR_W'(8'h61 + $urandom_range(alpha - 1)));
          if (text_q.size() == 0)
            repeat ($urandom_range(1, 5))
              text_q.push_back(CHAR_W'(8'h61 + $urandom_range(alpha - 1)));
        end
        foreach (text_q[i]) begin
          if ($urandom_range(39) == 0) send_load(SLOT_W'($urandom), make_token());
          send_char(text_q[i], i == text_q.size() - 1);
        end
      end
      phase++;
    end

    drain();
    $display("Run covered %0d items and %0d match counts over %0d register writes in %0d phases",
             n_items, sb.n_results, n_settings, phase);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/gtsm_pkg.sv
rtl/gtsm_cfg_regs.sv
rtl/gtsm_token_store.sv
rtl/greedy_token_subsequence_match_core.sv
tb/sv/greedy_token_subsequence_match_core_tb.sv
